>>> design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the range maximum query block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int DataW  = 32;
  localparam int IndexW = 10;
  localparam int CountW = 11;
  localparam int ApbW   = 32;
  localparam int AddrW  = 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CountW-1:0] COUNT_RESET = 11'd1024;

  // register index, taken from paddr[2]
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic emit;
  } rmq_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic ptr_at_hi;
    logic out_free;
  } rmq_status_t;

endpackage

`default_nettype wire

>>> design/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_req_if / rmq_rsp_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_req_if;
  import rmq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IndexW-1:0]        load_index;
  logic signed [DataW-1:0]  load_value;
  logic [IndexW-1:0]        query_low;
  logic [IndexW-1:0]        query_high;

  modport source (output valid, opcode, load_index, load_value, query_low, query_high,
                  input ready);
  modport sink   (input valid, opcode, load_index, load_value, query_low, query_high,
                  output ready);
endinterface

interface rmq_rsp_if;
  import rmq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DataW-1:0]  max_value;
  logic [IndexW-1:0]        max_position;
  logic                     range_error;

  modport source (output valid, max_value, max_position, range_error, input ready);
  modport sink   (input valid, max_value, max_position, range_error, output ready);
endinterface

`default_nettype wire

>>> design/rmq_ctrl.sv
// ----------------------------------------------------------------------------
// rmq_ctrl
// Sequencer: accepts requests, steps the scan and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_ctrl
  import rmq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  input  wire logic        req_opcode_i,
  output logic             req_ready_o,
  input  wire rmq_status_t status_i,
  output rmq_cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_opcode_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = status_i.range_ok ? ST_ISSUE : ST_HOLD;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (status_i.ptr_at_hi) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/rmq_datapath.sv
// ----------------------------------------------------------------------------
// rmq_datapath
// Element store, scan pointer, running maximum and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_datapath
  import rmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rmq_cmd_t                cmd_i,
  output rmq_status_t                  status_o,
  input  wire logic [CountW-1:0]       count_i,
  input  wire logic [IndexW-1:0]       load_index_i,
  input  wire logic signed [DataW-1:0] load_value_i,
  input  wire logic [IndexW-1:0]       query_low_i,
  input  wire logic [IndexW-1:0]       query_high_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [DataW-1:0]      max_value_o,
  output logic [IndexW-1:0]            max_position_o,
  output logic                         range_error_o
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int WW = (AW + 1 > CountW) ? AW + 1 : CountW;
  localparam logic [WW-1:0] MaxW = WW'(MAX_ELEMENTS);

  logic signed [DataW-1:0] mem [MAX_ELEMENTS];

  logic [WW-1:0] load_idx_w, lo_w, hi_w, cnt_w, cnt_eff, pos_w;
  logic          load_ok;

  logic [AW-1:0]           ptr_q, hi_q, rd_pos_q, best_pos_q;
  logic signed [DataW-1:0] rd_q, best_q;
  logic                    rd_vld_q, first_q, err_q, out_valid_q;

  assign load_idx_w = {{(WW-IndexW){1'b0}}, load_index_i};
  assign lo_w       = {{(WW-IndexW){1'b0}}, query_low_i};
  assign hi_w       = {{(WW-IndexW){1'b0}}, query_high_i};
  assign cnt_w      = {{(WW-CountW){1'b0}}, count_i};
  assign cnt_eff    = (cnt_w > MaxW) ? MaxW : cnt_w;
  assign load_ok    = load_idx_w < MaxW;

  assign status_o.range_ok  = (lo_w <= hi_w) && (hi_w < cnt_eff);
  assign status_o.ptr_at_hi = (ptr_q == hi_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      mem[load_idx_w[AW-1:0]] <= load_value_i;
    end
    if (cmd_i.issue) begin
      rd_q     <= mem[ptr_q];
      rd_pos_q <= ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ptr_q <= lo_w[AW-1:0];
      hi_q  <= hi_w[AW-1:0];
      err_q <= !status_o.range_ok;
    end else if (cmd_i.issue) begin
      ptr_q <= ptr_q + AW'(1);
    end
    if (rd_vld_q && (first_q || (rd_q > best_q))) begin
      best_q     <= rd_q;
      best_pos_q <= rd_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        first_q <= 1'b1;
      end else if (rd_vld_q) begin
        first_q <= 1'b0;
      end
    end
  end

  assign pos_w = {{(WW-AW){1'b0}}, best_pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      max_value_o    <= err_q ? '0 : best_q;
      max_position_o <= err_q ? '0 : pos_w[IndexW-1:0];
      range_error_o  <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> design/range_maximum_query_top.sv
// ----------------------------------------------------------------------------
// range_maximum_query_top
// Range maximum query over a loadable array of signed 32-bit elements.
//
// Requests enter on req_i (valid/ready). A load request writes one element
// and gives no result. A query request gives one result on rsp_o: the
// largest element in [query_low, query_high] and the lowest index holding
// it, or only range_error when the range is invalid. A query holds off new
// requests until its result is in the output register: the store has one
// read port, so the scan reads one element per cycle.
// The result sits in an output register; the block takes the next request
// while it waits, and a finished query holds until that register is free.
// Reset empties the pipeline and sets element_count to 1024; the store is
// not cleared and an element must be loaded before a query reads it.
// element_count is written over the APB port at address 0; the user must
// do so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module range_maximum_query_top
  import rmq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rmq_req_if.sink               req_i,
  rmq_rsp_if.source             rsp_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]       prdata,
  output logic                  pready
);

  logic [CountW-1:0] count_q;
  rmq_cmd_t          cmd;
  rmq_status_t       status;
  logic              req_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {{(ApbW-CountW){1'b0}}, count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT)) begin
      count_q <= pwdata[CountW-1:0];
    end
  end

  assign req_i.ready = req_ready;

  rmq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  rmq_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .count_i        (count_q),
    .load_index_i   (req_i.load_index),
    .load_value_i   (req_i.load_value),
    .query_low_i    (req_i.query_low),
    .query_high_i   (req_i.query_high),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .max_value_o    (rsp_o.max_value),
    .max_position_o (rsp_o.max_position),
    .range_error_o  (rsp_o.range_error)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_maximum_query_top. A scoreboard keeps its own
// copy of the element store and element_count, works out the maximum and its
// first position for every accepted query request, and compares each result
// field by field. Stimulus opens with loads and queries at the extremes, then
// runs randomised phases at several counts. Requests come in bursts and the
// result side stalls on shifting patterns, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rmq_pkg::*;

  localparam int ELEMENTS      = 1024;
  localparam int PHASE_ITEMS   = 95;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 40;
  localparam longint CYCLE_LIMIT = 2_500_000;
  localparam logic [AddrW-1:0] COUNT_ADDR = AddrW'({REG_ELEMENT_COUNT, 2'b00});

  typedef struct packed {
    logic                    opcode;
    logic [IndexW-1:0]       load_index;
    logic signed [DataW-1:0] load_value;
    logic [IndexW-1:0]       query_low;
    logic [IndexW-1:0]       query_high;
  } rmq_request_t;

  typedef struct packed {
    logic signed [DataW-1:0] max_value;
    logic [IndexW-1:0]       max_position;
    logic                    range_error;
  } max_result_t;

  class max_query_scoreboard;
    logic signed [DataW-1:0] elements [ELEMENTS];
    logic [CountW-1:0]       count_q;
    max_result_t             pending_maxima [$];
    int                      mismatches;

    function new();
      count_q = COUNT_RESET;
      mismatches = 0;
    endfunction

    function void set_count(logic [CountW-1:0] c);
      count_q = c;
    endfunction

    function void flag(string msg);
      if (mismatches < 10) begin
        $display("[%0t] %s", $realtime, msg);
      end
      mismatches++;
    endfunction

    function void note_request(rmq_request_t r);
      int unsigned lim;
      int unsigned pos;
      int unsigned i;
      logic signed [DataW-1:0] best;
      if (r.opcode == OP_LOAD) begin
        elements[r.load_index] = r.load_value;
        return;
      end
      lim = (count_q > ELEMENTS) ? ELEMENTS : int'(count_q);
      if (r.query_low > r.query_high || r.query_high >= lim) begin
        pending_maxima.push_back('{'0, '0, 1'b1});
        return;
      end
      pos = int'(r.query_low);
      best = elements[pos];
      for (i = int'(r.query_low) + 1; i <= int'(r.query_high); i++) begin
        if (elements[i] > best) begin
          best = elements[i];
          pos = i;
        end
      end
      pending_maxima.push_back('{best, IndexW'(pos), 1'b0});
    endfunction

    function void check_result(max_result_t got);
      max_result_t want;
      if (pending_maxima.size() == 0) begin
        flag($sformatf("unexpected result: value %0d pos %0d err %0b",
                       got.max_value, got.max_position, got.range_error));
        return;
      end
      want = pending_maxima.pop_front();
      if (got.max_value !== want.max_value || got.max_position !== want.max_position ||
          got.range_error !== want.range_error) begin
        flag($sformatf("mismatch: exp value %0d pos %0d err %0b, got value %0d pos %0d err %0b",
                       want.max_value, want.max_position, want.range_error,
                       got.max_value, got.max_position, got.range_error));
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [ApbW-1:0]  pwdata;
  logic [ApbW-1:0]  prdata;
  logic             pready;

  rmq_req_if req_if ();
  rmq_rsp_if rsp_if ();

  range_maximum_query_top #(
    .MAX_ELEMENTS(ELEMENTS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  max_query_scoreboard sb = new();
  bit     loaded [ELEMENTS];
  int     burst_left = 0;
  bit     hold_arm = 1'b0;
  longint cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // handshakes are sampled mid-cycle, where every signal has settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result('{rsp_if.max_value, rsp_if.max_position, rsp_if.range_error});
      end
      if (req_if.valid && req_if.ready) begin
        sb.note_request('{req_if.opcode, req_if.load_index, req_if.load_value,
                          req_if.query_low, req_if.query_high});
      end
    end
  end

  // result side: shifting stall patterns plus one long hold-off
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    bit hold_done;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= cycles[3];
        endcase
      end
    end
  end

  task automatic send_request(input rmq_request_t r);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.opcode     <= r.opcode;
    req_if.load_index <= r.load_index;
    req_if.load_value <= r.load_value;
    req_if.query_low  <= r.query_low;
    req_if.query_high <= r.query_high;
    do begin
      @(negedge clk_i);
      took = req_if.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic load_element(input int idx, input logic signed [DataW-1:0] val);
    rmq_request_t r;
    r.opcode     = OP_LOAD;
    r.load_index = IndexW'(idx);
    r.load_value = val;
    r.query_low  = IndexW'($urandom);
    r.query_high = IndexW'($urandom);
    loaded[idx]  = 1'b1;
    send_request(r);
  endtask

  task automatic query_range(input int lo, input int hi);
    rmq_request_t r;
    r.opcode     = OP_QUERY;
    r.load_index = IndexW'($urandom);
    r.load_value = $urandom;
    r.query_low  = IndexW'(lo);
    r.query_high = IndexW'(hi);
    send_request(r);
  endtask

  task automatic idle_requests();
    req_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // loads give no result, so the drain also waits SETTLE_CYCLES once no result is pending
  task automatic drain();
    while (sb.pending_maxima.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [ApbW-1:0] data);
    bit ok;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = pready;
      @(posedge clk_i);
    end while (!ok);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [AddrW-1:0] addr, input logic [ApbW-1:0] want);
    bit ok;
    logic [ApbW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = pready;
      got = prdata;
      @(posedge clk_i);
    end while (!ok);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      sb.flag($sformatf("register read: exp %0d, got %0d", want, got));
    end
  endtask

  function automatic logic signed [DataW-1:0] element_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit span_loaded(input int lo, input int hi);
    int i;
    for (i = lo; i <= hi; i++) begin
      if (!loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    int ph;
    int n;
    int roll;
    int cnt;
    int cur_count;
    int fill_ptr;
    int lo;
    int hi;
    int top;
    int span;
    int idx;

    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_LOAD;
    req_if.load_index = '0;
    req_if.load_value = '0;
    req_if.query_low  = '0;
    req_if.query_high = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cur_count         = int'(COUNT_RESET);
    fill_ptr          = 5;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_read_check(COUNT_ADDR, ApbW'(COUNT_RESET));

    // extremes, ties and the top of the store at the reset count
    load_element(0, 32'sh7fff_ffff);
    load_element(1, 32'sh8000_0000);
    load_element(2, 0);
    load_element(3, 32'sh7fff_ffff);
    load_element(4, -1);
    load_element(1021, 32'sh8000_0000);
    load_element(1022, 32'sh7fff_ffff);
    load_element(1023, -5);
    query_range(0, 0);
    query_range(1, 1);
    query_range(0, 4);
    query_range(1, 2);
    query_range(1, 4);
    query_range(2, 1);
    query_range(1023, 0);
    query_range(1021, 1023);
    query_range(1023, 1023);
    query_range(1021, 1022);
    idle_requests();
    drain();

    // single element in use
    apb_write(COUNT_ADDR, ApbW'(1));
    sb.set_count(CountW'(1));
    query_range(0, 0);
    query_range(0, 1);
    query_range(1023, 1023);
    idle_requests();
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cnt = ELEMENTS;
        1: cnt = $urandom_range(2, 64);
        2: cnt = 1;
        3: cnt = $urandom_range(65, ELEMENTS - 1);
        4: cnt = ELEMENTS;
        default: cnt = 2;
      endcase
      apb_write(COUNT_ADDR, ApbW'(cnt));
      sb.set_count(CountW'(cnt));
      apb_read_check(COUNT_ADDR, ApbW'(cnt));
      cur_count = cnt;
      if (ph == 0) hold_arm <= 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          if ($urandom_range(0, 9) < 7 && fill_ptr < ELEMENTS - 1) begin
            idx = fill_ptr;
            fill_ptr++;
          end else begin
            idx = $urandom_range(0, ELEMENTS - 1);
          end
          load_element(idx, element_value());
        end else if (roll < 85) begin
          // well-formed query over loaded elements
          top = (fill_ptr < cur_count) ? fill_ptr : cur_count;
          lo = ($urandom_range(0, 9) < 6) ? $urandom_range(0, top - 1)
                                          : $urandom_range(0, cur_count - 1);
          if (!loaded[lo]) begin
            load_element(lo, element_value());
          end else begin
            case ($urandom_range(0, 7))
              0: span = ELEMENTS - 1;
              1, 2, 3: span = 15;
              default: span = 3;
            endcase
            hi = lo;
            while (hi - lo < span && hi + 1 < cur_count && loaded[hi + 1]) hi++;
            query_range(lo, hi);
          end
        end else begin
          // arbitrary bounds; a valid range over unloaded elements is turned round, or loaded when lo equals hi
          lo = $urandom_range(0, ELEMENTS - 1);
          hi = $urandom_range(0, ELEMENTS - 1);
          if (lo <= hi && hi < cur_count && !span_loaded(lo, hi)) begin
            if (lo != hi) begin
              query_range(hi, lo);
            end else begin
              load_element(lo, element_value());
            end
          end else begin
            query_range(lo, hi);
          end
        end
      end
      idle_requests();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_maxima.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
